>>> rtl/core/imusa_pkg.sv
// Shared types and constants for the IMU sample averager.
package imusa_pkg;

    localparam int AXIS_W = 16;
    localparam int ONE_G_W = 15;
    localparam logic [ONE_G_W-1:0] ONE_G_RESET = 15'd4096;

    // Input kinds as they arrive on the stream.
    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_RATE_READ = 2'd1;
    localparam logic [1:0] KIND_ACCEL_READ = 2'd2;

    // Register index of accel_one_g, taken from paddr[2].
    localparam logic REG_ONE_G = 1'b0;

    typedef enum logic [1:0] {
        CMD_SAMPLE,
        CMD_RATE_READ,
        CMD_ACCEL_READ
    } cmd_t;

    typedef struct packed {
        cmd_t                      cmd;
        logic signed [AXIS_W-1:0] ax;
        logic signed [AXIS_W-1:0] ay;
        logic signed [AXIS_W-1:0] az;
        logic signed [AXIS_W-1:0] rx;
        logic signed [AXIS_W-1:0] ry;
        logic signed [AXIS_W-1:0] rz;
    } cmd_entry_t;

    typedef struct packed {
        logic signed [AXIS_W-1:0] avg_x;
        logic signed [AXIS_W-1:0] avg_y;
        logic signed [AXIS_W-1:0] avg_z;
        logic                     has_data;
        logic                     overflowed;
    } result_t;

endpackage

>>> rtl/core/imusa_front.sv
// Input stage: accepts transfers, classifies them and queues commands for the back end.
module imusa_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [103:0]          s_axis_tdata,
    input  logic [1:0]            s_axis_tuser,
    output logic                  cmd_valid,
    input  logic                  cmd_ready,
    output imusa_pkg::cmd_entry_t cmd_entry
);

    imusa_pkg::cmd_entry_t q_mem_reg [2];
    logic                  wr_ptr_reg;
    logic                  rd_ptr_reg;
    logic [1:0]            fill_reg;
    imusa_pkg::cmd_entry_t in_entry;
    logic                  in_keep;
    logic                  push;
    logic                  pop;

    // Failed sample transfers and the unused kind are accepted and dropped here.
    always_comb
    begin
        in_entry.cmd = imusa_pkg::CMD_SAMPLE;
        in_keep = 1'b0;
        case (s_axis_tuser)
            imusa_pkg::KIND_SAMPLE:
            begin
                in_entry.cmd = imusa_pkg::CMD_SAMPLE;
                in_keep = s_axis_tdata[0];
            end
            imusa_pkg::KIND_RATE_READ:
            begin
                in_entry.cmd = imusa_pkg::CMD_RATE_READ;
                in_keep = 1'b1;
            end
            imusa_pkg::KIND_ACCEL_READ:
            begin
                in_entry.cmd = imusa_pkg::CMD_ACCEL_READ;
                in_keep = 1'b1;
            end
            default:
            begin
                in_entry.cmd = imusa_pkg::CMD_SAMPLE;
                in_keep = 1'b0;
            end
        endcase
        in_entry.ax = s_axis_tdata[16:1];
        in_entry.ay = s_axis_tdata[32:17];
        in_entry.az = s_axis_tdata[48:33];
        in_entry.rx = s_axis_tdata[64:49];
        in_entry.ry = s_axis_tdata[80:65];
        in_entry.rz = s_axis_tdata[96:81];
    end

    assign s_axis_tready = (fill_reg != 2'd2);
    assign push = s_axis_tvalid && s_axis_tready && in_keep;
    assign cmd_valid = (fill_reg != 2'd0);
    assign pop = cmd_valid && cmd_ready;
    assign cmd_entry = q_mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= in_entry;
        end
    end

endmodule

>>> rtl/core/imusa_div.sv
// Serial signed divider: one restoring step per cycle, truncates toward zero.
module imusa_div
#(
    parameter int SUM_W = 24,
    parameter int CNT_W = 8
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [SUM_W-1:0]             dividend,
    input  logic [CNT_W-1:0]                    divisor,
    output logic                                done,
    output logic signed [imusa_pkg::AXIS_W-1:0] quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  mag_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  dvs_reg;
    logic [STEP_W-1:0] step_reg;
    logic              neg_reg;
    logic              done_reg;
    logic [CNT_W:0]    trial;
    logic              qbit;
    logic [SUM_W-1:0]  signed_q;

    assign trial = {rem_reg, mag_reg[SUM_W-1]};
    assign qbit = (trial >= {1'b0, dvs_reg});
    // The divisor is a count, so the quotient sign follows the dividend alone.
    assign signed_q = neg_reg ? (~mag_reg + SUM_W'(1)) : mag_reg;
    assign quotient = signed_q[imusa_pkg::AXIS_W-1:0];
    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (step_reg == STEP_W'(1));
            if (start)
            begin
                step_reg <= STEP_W'(SUM_W);
            end
            else if (step_reg != '0)
            begin
                step_reg <= step_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[SUM_W-1];
            mag_reg <= dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (step_reg != '0)
        begin
            mag_reg <= {mag_reg[SUM_W-2:0], qbit};
            rem_reg <= qbit ? CNT_W'(trial - {1'b0, dvs_reg}) : trial[CNT_W-1:0];
        end
    end

endmodule

>>> rtl/core/imusa_back.sv
// Back end: per-axis accumulators, read sequencing and the result register.
module imusa_back
#(
    parameter int MAX_COUNT = 255,
    parameter int CNT_W = 8,
    parameter int SUM_W = 24
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    output logic                             cmd_ready,
    input  imusa_pkg::cmd_entry_t            cmd_entry,
    input  logic [imusa_pkg::ONE_G_W-1:0]    one_g,
    output logic                             res_valid,
    input  logic                             res_ready,
    output imusa_pkg::result_t               res
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_FINISH
    } state_t;

    state_t                           state_reg;
    logic signed [SUM_W-1:0]          acc_sum_reg [3];
    logic signed [SUM_W-1:0]          rate_sum_reg [3];
    logic [CNT_W-1:0]                 acc_cnt_reg;
    logic [CNT_W-1:0]                 rate_cnt_reg;
    logic                             acc_drop_reg;
    logic                             rate_drop_reg;
    logic                             sel_accel_reg;
    logic [1:0]                       axis_reg;
    logic signed [imusa_pkg::AXIS_W-1:0] avg_reg [3];
    logic                             res_valid_reg;
    imusa_pkg::result_t               res_reg;

    logic signed [SUM_W-1:0]          div_dividend;
    logic [CNT_W-1:0]                 div_divisor;
    logic                             div_start;
    logic                             div_done;
    logic signed [imusa_pkg::AXIS_W-1:0] div_quotient;
    logic [CNT_W-1:0]                 sel_cnt;
    logic                             sel_drop;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res = res_reg;

    assign sel_cnt = sel_accel_reg ? acc_cnt_reg : rate_cnt_reg;
    assign sel_drop = sel_accel_reg ? acc_drop_reg : rate_drop_reg;
    assign div_dividend = sel_accel_reg ? acc_sum_reg[axis_reg] : rate_sum_reg[axis_reg];
    assign div_divisor = sel_cnt;
    assign div_start = (state_reg == ST_DIV_START);

    imusa_div
    #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    )
    u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            for (int i = 0; i < 3; i++)
            begin
                acc_sum_reg[i] <= '0;
                rate_sum_reg[i] <= '0;
            end
            acc_cnt_reg <= '0;
            rate_cnt_reg <= '0;
            acc_drop_reg <= 1'b0;
            rate_drop_reg <= 1'b0;
            sel_accel_reg <= 1'b0;
            axis_reg <= 2'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            // In the finish state the valid flag is driven by the hand-over below.
            if (res_valid_reg && res_ready && (state_reg != ST_FINISH))
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        case (cmd_entry.cmd)
                            imusa_pkg::CMD_SAMPLE:
                            begin
                                // Each sensor saturates on its own count.
                                if (rate_cnt_reg < CNT_W'(MAX_COUNT))
                                begin
                                    rate_sum_reg[0] <= rate_sum_reg[0] + SUM_W'(cmd_entry.rx);
                                    rate_sum_reg[1] <= rate_sum_reg[1] + SUM_W'(cmd_entry.ry);
                                    rate_sum_reg[2] <= rate_sum_reg[2] + SUM_W'(cmd_entry.rz);
                                    rate_cnt_reg <= rate_cnt_reg + CNT_W'(1);
                                end
                                else
                                begin
                                    rate_drop_reg <= 1'b1;
                                end
                                if (acc_cnt_reg < CNT_W'(MAX_COUNT))
                                begin
                                    acc_sum_reg[0] <= acc_sum_reg[0] + SUM_W'(cmd_entry.ax);
                                    acc_sum_reg[1] <= acc_sum_reg[1] + SUM_W'(cmd_entry.ay);
                                    acc_sum_reg[2] <= acc_sum_reg[2] + SUM_W'(cmd_entry.az);
                                    acc_cnt_reg <= acc_cnt_reg + CNT_W'(1);
                                end
                                else
                                begin
                                    acc_drop_reg <= 1'b1;
                                end
                            end
                            imusa_pkg::CMD_RATE_READ:
                            begin
                                sel_accel_reg <= 1'b0;
                                axis_reg <= 2'd0;
                                state_reg <= (rate_cnt_reg == '0) ? ST_FINISH : ST_DIV_START;
                            end
                            imusa_pkg::CMD_ACCEL_READ:
                            begin
                                sel_accel_reg <= 1'b1;
                                axis_reg <= 2'd0;
                                state_reg <= (acc_cnt_reg == '0) ? ST_FINISH : ST_DIV_START;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_DIV_START:
                begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        avg_reg[axis_reg] <= div_quotient;
                        if (axis_reg == 2'd2)
                        begin
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            axis_reg <= axis_reg + 2'd1;
                            state_reg <= ST_DIV_START;
                        end
                    end
                end
                ST_FINISH:
                begin
                    if (!res_valid_reg || res_ready)
                    begin
                        res_valid_reg <= 1'b1;
                        res_reg.overflowed <= sel_drop;
                        if (sel_cnt != '0)
                        begin
                            res_reg.avg_x <= avg_reg[0];
                            res_reg.avg_y <= avg_reg[1];
                            res_reg.avg_z <= avg_reg[2];
                            res_reg.has_data <= 1'b1;
                        end
                        else
                        begin
                            res_reg.avg_x <= '0;
                            res_reg.avg_y <= '0;
                            res_reg.avg_z <= sel_accel_reg
                                ? imusa_pkg::AXIS_W'({1'b0, one_g}) : '0;
                            res_reg.has_data <= 1'b0;
                        end
                        if (sel_accel_reg)
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                acc_sum_reg[i] <= '0;
                            end
                            acc_cnt_reg <= '0;
                            acc_drop_reg <= 1'b0;
                        end
                        else
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                rate_sum_reg[i] <= '0;
                            end
                            rate_cnt_reg <= '0;
                            rate_drop_reg <= 1'b0;
                        end
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        res_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/core/imu_sample_averager.sv
// IMU sample averager top level: stream ports, APB register and the two halves.
//
// A sample transfer is taken by the back end in its idle state. A read
// divides each axis in turn when the sensor holds samples (SUM_W is 24 at
// the default MAX_COUNT) and skips the divider when it is empty. The
// read time is set by the serial divider, which retires one quotient bit per
// cycle for each axis in turn. A two-entry command queue sits in front, so
// the input side keeps taking transfers, until both entries are full, while
// a read is being divided or a result waits on the output. Failed sample
// transfers and kind 3 are taken and discarded. accel_one_g sits at APB address 0.
module imu_sample_averager
#(
    parameter int MAX_COUNT = 255
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // bus_ack, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, zero fill
    input  logic [103:0] s_axis_tdata,
    // kind
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // avg_x, avg_y, avg_z, has_data, overflowed, zero fill
    output logic [55:0]  m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int CNT_W = $clog2(MAX_COUNT + 1);
    localparam int SUM_W = imusa_pkg::AXIS_W + CNT_W;

    logic [imusa_pkg::ONE_G_W-1:0] one_g_reg;
    logic                          cmd_valid;
    logic                          cmd_ready;
    imusa_pkg::cmd_entry_t         cmd_entry;
    imusa_pkg::result_t            res;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == imusa_pkg::REG_ONE_G)
        ? {{(32 - imusa_pkg::ONE_G_W){1'b0}}, one_g_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_g_reg <= imusa_pkg::ONE_G_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == imusa_pkg::REG_ONE_G))
        begin
            one_g_reg <= pwdata[imusa_pkg::ONE_G_W-1:0];
        end
    end

    imusa_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd_entry     (cmd_entry)
    );

    imusa_back
    #(
        .MAX_COUNT (MAX_COUNT),
        .CNT_W     (CNT_W),
        .SUM_W     (SUM_W)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_entry (cmd_entry),
        .one_g     (one_g_reg),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tdata = {6'd0, res.overflowed, res.has_data,
                           res.avg_z, res.avg_y, res.avg_x};

endmodule

>>> rtl/core/imusa_checker.sv
// Port-level checks for the IMU sample averager, bound to the top level.
module imusa_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [55:0]  m_axis_tdata,
    input logic         psel,
    input logic         penable,
    input logic         pwrite,
    input logic [2:0]   paddr,
    input logic [31:0]  pwdata,
    input logic [31:0]  prdata
);

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // An empty read reports zero on X and Y.
    a_empty_xy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[48] |-> m_axis_tdata[31:0] == 32'd0)
        else $error("empty read with nonzero X or Y");

    // The one-g register reads back what was last written.
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && !paddr[2]) ##1 !paddr[2]
        |-> prdata[14:0] == $past(pwdata[14:0]))
        else $error("one-g register readback mismatch");

    // Unused register bits read as zero.
    a_cfg_upper: assert property (@(posedge clk) disable iff (!rst_n)
        prdata[31:15] == 17'd0)
        else $error("upper register bits not zero");

endmodule

bind imu_sample_averager imusa_checker u_imusa_checker (.*);
